// ===== rtl/bgpc_pkg.sv =====
// Shared constants and types for the banded gradient pixel color block.
`default_nettype none

package bgpc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned NUM_CHAN       = 4;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  // Bit position of each channel inside an RGBA8888 word, red first.
  localparam int unsigned CHAN_SHIFT [NUM_CHAN] = '{24, 16, 8, 0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_EDGE_COLOR    = 3'd2,
    CFG_BAND_COLOR    = 3'd3,
    CFG_VERTICAL_MODE = 3'd4,
    CFG_BAND_SIZE     = 3'd5
  } cfg_reg_t;

  // Where a pixel sits along the gradient axis.
  typedef enum logic [1:0] {
    RGN_BAND      = 2'd0,
    RGN_RAMP_UP   = 2'd1,
    RGN_RAMP_DOWN = 2'd2,
    RGN_EDGE      = 2'd3
  } region_t;

endpackage

`default_nettype wire

// ===== rtl/bgpc_if.sv =====
// Valid/ready channel interfaces: pixel coordinate in, RGBA color out.
`default_nettype none

interface bgpc_coord_if #(
  parameter int unsigned COORD_BITS = bgpc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bgpc_color_if;
  logic                        valid;
  logic                        ready;
  logic [bgpc_pkg::CHAN_W-1:0] red_out;
  logic [bgpc_pkg::CHAN_W-1:0] green_out;
  logic [bgpc_pkg::CHAN_W-1:0] blue_out;
  logic [bgpc_pkg::CHAN_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/banded_gradient_pixel_color.sv =====
// Banded gradient pixel color: pipelined coordinate-to-RGBA8888 color generator.
//
// Usage:
//   coord : valid/ready channel carrying pixel_x, pixel_y. One transfer per clock while coord.ready is high.
//   color : valid/ready channel carrying red_out, green_out, blue_out, alpha_out,
//           one result per coordinate, in order.
//   wr_en/wr_index/wr_data : register writes, taken on any edge with wr_en high;
//           write only while no pixel is in flight.
// Throughput: one pixel per clock, sustained, as long as color.ready stays high.
// Pipeline: input, classify and multiply registers, then the restoring divider
//   (one quotient bit per stage, 8 + COORD_BITS stages, the four channels side
//   by side), then the output register.
// Stall: the output register is backed by a one-entry skid buffer. While the
//   receiver holds off, one more result is parked in the skid buffer; then the
//   whole pipeline freezes and coord.ready drops. Nothing is dropped or repeated.
// Reset (rst, synchronous): empties the pipeline and output, sets both screen sizes
//   to 1 and every other register to 0. A pixel may be sent on the first cycle after.
`default_nettype none

module banded_gradient_pixel_color #(
  parameter int unsigned COORD_BITS = bgpc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [bgpc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [bgpc_pkg::CFG_DATA_W-1:0]     wr_data,
  bgpc_coord_if.sink                          coord,
  bgpc_color_if.source                        color
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned CW   = bgpc_pkg::CHAN_W;
  localparam int unsigned NCH  = bgpc_pkg::NUM_CHAN;
  localparam int unsigned QW   = CW + CB;   // dividend and quotient width
  localparam int unsigned NDIV = QW;        // one quotient bit per stage

  // ---------------------------------------------------------------- registers
  logic [CB-1:0]                     screen_width;
  logic [CB-1:0]                     screen_height;
  logic [bgpc_pkg::CFG_DATA_W-1:0]   edge_color;
  logic [bgpc_pkg::CFG_DATA_W-1:0]   band_color;
  logic                              vertical_mode;
  logic [CB-1:0]                     band_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CB'(1);
      screen_height <= CB'(1);
      edge_color    <= '0;
      band_color    <= '0;
      vertical_mode <= 1'b0;
      band_size     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        bgpc_pkg::CFG_SCREEN_WIDTH:  screen_width  <= wr_data[CB-1:0];
        bgpc_pkg::CFG_SCREEN_HEIGHT: screen_height <= wr_data[CB-1:0];
        bgpc_pkg::CFG_EDGE_COLOR:    edge_color    <= wr_data;
        bgpc_pkg::CFG_BAND_COLOR:    band_color    <= wr_data;
        bgpc_pkg::CFG_VERTICAL_MODE: vertical_mode <= wr_data[0];
        bgpc_pkg::CFG_BAND_SIZE:     band_size     <= wr_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // Band limits, registered from the configuration registers.
  logic [CB-1:0] axis_len;
  logic [CB-1:0] band_clamp;
  logic [CB-2:0] axis_start;
  logic [CB-1:0] axis_end;

  always_comb begin
    axis_len   = vertical_mode ? screen_width : screen_height;
    band_clamp = (band_size > axis_len) ? axis_len : band_size;
  end

  always_ff @(posedge clk) begin
    axis_start <= (CB-1)'((axis_len >> 1) - (band_clamp >> 1));
    axis_end   <= (axis_len >> 1) + (band_clamp >> 1);
  end

  // ------------------------------------------------------------ flow control
  logic adv;        // whole pipeline moves
  logic out_v;
  logic skid_v;

  assign adv         = !skid_v;
  assign coord.ready = adv;

  // ----------------------------------------------------------- stage A: input
  logic          a_v;
  logic [CB-1:0] a_x;
  logic [CB-1:0] a_y;

  // ------------------------------------------------------- stage B: classify
  logic                        b_v;
  bgpc_pkg::region_t           b_rgn;
  logic [CB-1:0]               b_off;
  logic [NCH-1:0][CW-1:0]      b_dmag;
  logic [NCH-1:0]              b_dneg;

  logic [CB-1:0]               t_axis;
  bgpc_pkg::region_t           rgn_next;
  logic [CB-1:0]               off_next;
  logic [NCH-1:0][CW-1:0]      c1;
  logic [NCH-1:0][CW-1:0]      c2;
  logic [NCH-1:0][CW-1:0]      dmag_next;
  logic [NCH-1:0]              dneg_next;

  always_comb begin
    t_axis = vertical_mode ? a_x : a_y;
    off_next = t_axis;
    priority if (t_axis < {1'b0, axis_start}) begin
      rgn_next = bgpc_pkg::RGN_RAMP_UP;
    end else if (t_axis < axis_end) begin
      rgn_next = bgpc_pkg::RGN_BAND;
    end else if (axis_start == '0) begin
      rgn_next = bgpc_pkg::RGN_EDGE;   // no ramp length to divide by
    end else begin
      rgn_next = bgpc_pkg::RGN_RAMP_DOWN;
      off_next = t_axis - axis_end;
    end
    for (int ch = 0; ch < NCH; ch++) begin
      c1[ch]        = edge_color[bgpc_pkg::CHAN_SHIFT[ch] +: CW];
      c2[ch]        = band_color[bgpc_pkg::CHAN_SHIFT[ch] +: CW];
      dneg_next[ch] = c2[ch] < c1[ch];
      dmag_next[ch] = dneg_next[ch] ? (c1[ch] - c2[ch]) : (c2[ch] - c1[ch]);
    end
  end

  // ------------------------------- entry 0: product, entries 1..NDIV: divider
  logic [NDIV:0]           dv;
  bgpc_pkg::region_t       drgn [NDIV+1];
  logic [NCH-1:0]          dneg [NDIV+1];
  logic [QW-1:0]           dnum [NDIV+1][NCH];
  logic [CB-2:0]           drem [NDIV+1][NCH];

  logic [CB-1:0]           trial    [NDIV][NCH];
  logic [QW-1:0]           num_next [NDIV][NCH];
  logic [CB-2:0]           rem_next [NDIV][NCH];

  // Restoring division: shift one dividend bit into the remainder, subtract the
  // ramp length if it fits, shift the quotient bit into the low end of num.
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        trial[k][ch] = {drem[k][ch], dnum[k][ch][QW-1]};
        if (trial[k][ch] >= {1'b0, axis_start}) begin
          rem_next[k][ch] = (CB-1)'(trial[k][ch] - {1'b0, axis_start});
          num_next[k][ch] = {dnum[k][ch][QW-2:0], 1'b1};
        end else begin
          rem_next[k][ch] = trial[k][ch][CB-2:0];
          num_next[k][ch] = {dnum[k][ch][QW-2:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------- finishing
  logic                    fin_v;
  logic [NCH-1:0][CW-1:0]  fin_data;
  logic [NCH-1:0][CW-1:0]  quo;
  logic [NCH-1:0][CW-1:0]  squo;

  always_comb begin
    fin_v = dv[NDIV];
    for (int ch = 0; ch < NCH; ch++) begin
      quo[ch]  = dnum[NDIV][ch][CW-1:0];
      squo[ch] = dneg[NDIV][ch] ? CW'(~quo[ch] + CW'(1)) : quo[ch];
      unique case (drgn[NDIV])
        bgpc_pkg::RGN_BAND:      fin_data[ch] = c2[ch];
        bgpc_pkg::RGN_RAMP_UP:   fin_data[ch] = c1[ch] + squo[ch];
        bgpc_pkg::RGN_RAMP_DOWN: fin_data[ch] = c2[ch] - squo[ch];
        bgpc_pkg::RGN_EDGE:      fin_data[ch] = c1[ch];
        default:                 fin_data[ch] = c1[ch];
      endcase
    end
  end

  // ------------------------------------------------------------ valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      dv  <= '0;
    end else if (adv) begin
      a_v <= coord.valid;
      b_v <= a_v;
      dv  <= {dv[NDIV-1:0], b_v};
    end
  end

  // --------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_x    <= coord.pixel_x;
      a_y    <= coord.pixel_y;
      b_rgn  <= rgn_next;
      b_off  <= off_next;
      b_dmag <= dmag_next;
      b_dneg <= dneg_next;
      drgn[0] <= b_rgn;
      dneg[0] <= b_dneg;
      for (int ch = 0; ch < NCH; ch++) begin
        dnum[0][ch] <= QW'(b_dmag[ch]) * QW'(b_off);
        drem[0][ch] <= '0;
      end
      for (int k = 0; k < NDIV; k++) begin
        drgn[k+1] <= drgn[k];
        dneg[k+1] <= dneg[k];
        for (int ch = 0; ch < NCH; ch++) begin
          dnum[k+1][ch] <= num_next[k][ch];
          drem[k+1][ch] <= rem_next[k][ch];
        end
      end
    end
  end

  // ------------------------------------------------- output register + skid
  logic [NCH-1:0][CW-1:0] out_data;
  logic [NCH-1:0][CW-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || color.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= fin_v;
      end
    end else if (fin_v && adv) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || color.ready) begin
      out_data <= skid_v ? skid_data : fin_data;
    end else if (adv) begin
      skid_data <= fin_data;
    end
  end

  assign color.valid     = out_v;
  assign color.red_out   = out_data[0];
  assign color.green_out = out_data[1];
  assign color.blue_out  = out_data[2];
  assign color.alpha_out = out_data[3];

  // -------------------------------------------------------------- assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid buffer holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_v && color.ready |=> out_v && !skid_v && out_data == $past(skid_data))
    else $error("parked result not moved to the output register");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv) && $stable(a_v) && $stable(b_v))
    else $error("pipeline moved while frozen");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_v && !skid_v && dv == '0 && !a_v && !b_v)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
